// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/cbc_pkg.sv
// Package with types, cube tables and helpers for the cull and project unit.
package cbc_pkg;

    localparam int FACE_COUNT_DEF = 6;
    localparam int CORNERS = 6;
    localparam logic [30:0] SDIST_RESET = 31'd65536;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic [2:0]         face_number;
        logic [2:0]         corner_slot;
        logic               vertex_valid;
        logic               divide_fault;
        logic [2:0]         visible_faces;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'b0001,
        OP_LOAD  = 4'b0010,
        OP_CULL  = 4'b0100,
        OP_PROJ  = 4'b1000
    } t_op;

    typedef struct packed {
        logic       load;
        logic       cull;
        logic       proj_start;
        logic [2:0] face;
        logic [2:0] slot;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic [5:0] vis;
    } t_status;

    // Corner coordinates in half units.
    function automatic logic signed [3:0] corner_half(input logic [2:0] c,
                                                      input logic [1:0] axis);
        logic signed [3:0] v;
        v = 4'sd0;
        case (axis)
            2'd0: v = c[1] ^ c[0] ? 4'sd1 : -4'sd1;
            2'd1: v = c[1] ? 4'sd1 : -4'sd1;
            2'd2: v = c[2] ? 4'sd7 : 4'sd5;
            default: v = 4'sd0;
        endcase
        if (axis == 2'd0) begin
            v = (c[1:0] == 2'd2 || c[1:0] == 2'd3) ? 4'sd1 : -4'sd1;
        end
        if (axis == 2'd1) begin
            v = (c[1:0] == 2'd1 || c[1:0] == 2'd2) ? 4'sd1 : -4'sd1;
        end
        return v;
    endfunction

    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [2:0] s);
        logic [17:0] row;
        logic [2:0]  r;
        case (f)
            3'd0: row = {3'd0, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0};
            3'd1: row = {3'd7, 3'd4, 3'd5, 3'd5, 3'd6, 3'd7};
            3'd2: row = {3'd4, 3'd0, 3'd1, 3'd1, 3'd5, 3'd4};
            3'd3: row = {3'd3, 3'd7, 3'd6, 3'd6, 3'd2, 3'd3};
            3'd4: row = {3'd1, 3'd2, 3'd6, 3'd6, 3'd5, 3'd1};
            3'd5: row = {3'd3, 3'd0, 3'd4, 3'd4, 3'd7, 3'd3};
            default: row = '0;
        endcase
        case (s)
            3'd0: r = row[2:0];
            3'd1: r = row[5:3];
            3'd2: r = row[8:6];
            3'd3: r = row[11:9];
            3'd4: r = row[14:12];
            3'd5: r = row[17:15];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cbc_div.sv
// Serial signed divider with saturation for one projected coordinate.
module cbc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [65:0] i_num,
    input  logic signed [33:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot,
    output logic               o_fault
);
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [65:0] r_q, n_q;
    logic [33:0] r_rem, n_rem;
    logic [33:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [31:0] r_quot, n_quot;
    logic        r_fault, n_fault;
    logic [34:0] trial;
    logic [33:0] shifted_rem;
    logic [66:0] sq;

    always_comb begin
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_q = r_q;
        n_rem = r_rem;
        n_den = r_den;
        n_neg = r_neg;
        n_done = 1'b0;
        n_quot = r_quot;
        n_fault = r_fault;
        shifted_rem = {r_rem[32:0], r_q[65]};
        trial = {1'b0, shifted_rem} - {1'b0, r_den};
        sq = '0;
        if (i_start) begin
            n_neg = i_num[65] ^ i_den[33];
            n_q = i_num[65] ? 66'(-i_num) : 66'(i_num);
            n_den = i_den[33] ? 34'(-i_den) : 34'(i_den);
            n_rem = '0;
            n_cnt = '0;
            if (i_den == '0) begin
                n_done = 1'b1;
                n_fault = 1'b1;
                n_quot = (i_num == '0) ? 32'sd0 : (i_num[65] ? QMIN : QMAX);
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_q = {r_q[64:0], ~trial[34]};
            n_rem = trial[34] ? shifted_rem : trial[33:0];
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd65) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                sq = r_neg ? -{1'b0, n_q} : {1'b0, n_q};
                if ($signed(sq) > 67'sd2147483647) begin
                    n_quot = QMAX;
                    n_fault = 1'b1;
                end else if ($signed(sq) < -67'sd2147483648) begin
                    n_quot = QMIN;
                    n_fault = 1'b1;
                end else begin
                    n_quot = sq[31:0];
                    n_fault = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_quot <= n_quot;
        r_fault <= n_fault;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_fault = r_fault;
endmodule

// File: rtl/cbc_datapath.sv
// Datapath: eye register, face culling test and two serial projection divides.
module cbc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbc_pkg::t_cmd         i_cmd,
    input  cbc_pkg::t_in_item     i_item,
    input  logic [30:0]           i_sdist,
    output cbc_pkg::t_status      o_status,
    output logic signed [31:0]    o_px,
    output logic signed [31:0]    o_py,
    output logic                  o_fault
);
    import cbc_pkg::*;

    logic signed [31:0] r_ex, r_ey, r_ez;
    logic [5:0]         r_vis;
    logic signed [65:0] r_nx, r_ny;
    logic signed [33:0] r_dep;
    logic               r_go;
    logic               dx_done, dy_done, dx_f, dy_f;
    logic               r_xd, r_yd;
    logic [2:0]         c0, c1, c2, cp;
    logic signed [4:0]  a[3], b[3];
    logic signed [9:0]  nrm[3];
    logic signed [33:0] d[3];
    logic signed [45:0] dot;
    logic signed [33:0] dpx, dpy;

    always_comb begin
        c0 = face_corner(i_cmd.face, 3'd0);
        c1 = face_corner(i_cmd.face, 3'd1);
        c2 = face_corner(i_cmd.face, 3'd2);
        for (int i = 0; i < 3; i++) begin
            a[i] = 5'(corner_half(c1, 2'(i))) - 5'(corner_half(c0, 2'(i)));
            b[i] = 5'(corner_half(c2, 2'(i))) - 5'(corner_half(c1, 2'(i)));
        end
        nrm[0] = 10'(a[1] * b[2]) - 10'(a[2] * b[1]);
        nrm[1] = 10'(a[2] * b[0]) - 10'(a[0] * b[2]);
        nrm[2] = 10'(a[0] * b[1]) - 10'(a[1] * b[0]);
        d[0] = 34'(corner_half(c0, 2'd0)) * 34'sd32768 - 34'(r_ex);
        d[1] = 34'(corner_half(c0, 2'd1)) * 34'sd32768 - 34'(r_ey);
        d[2] = 34'(corner_half(c0, 2'd2)) * 34'sd32768 - 34'(r_ez);
        dot = 46'(nrm[0]) * 46'(d[0]) + 46'(nrm[1]) * 46'(d[1])
            + 46'(nrm[2]) * 46'(d[2]);
        cp = face_corner(i_cmd.face, i_cmd.slot);
        dpx = 34'(corner_half(cp, 2'd0)) * 34'sd32768 - 34'(r_ex);
        dpy = 34'(corner_half(cp, 2'd1)) * 34'sd32768 - 34'(r_ey);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ex <= i_item.eye_x;
            r_ey <= i_item.eye_y;
            r_ez <= i_item.eye_z;
        end
        if (i_cmd.proj_start) begin
            r_nx <= 66'(dpx) * 66'($signed({1'b0, i_sdist}));
            r_ny <= 66'(dpy) * 66'($signed({1'b0, i_sdist}));
            r_dep <= 34'(corner_half(cp, 2'd2)) * 34'sd32768 - 34'(r_ez);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis <= '0;
            r_go <= 1'b0;
            r_xd <= 1'b0;
            r_yd <= 1'b0;
        end else begin
            r_go <= i_cmd.proj_start;
            if (i_cmd.load) begin
                r_vis <= '0;
            end else if (i_cmd.cull) begin
                r_vis[i_cmd.face] <= dot < 0;
            end
            if (i_cmd.proj_start) begin
                r_xd <= 1'b0;
                r_yd <= 1'b0;
            end else begin
                r_xd <= r_xd | dx_done;
                r_yd <= r_yd | dy_done;
            end
        end
    end

    cbc_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go), .i_num(r_nx),
        .i_den(r_dep), .o_done(dx_done), .o_quot(o_px), .o_fault(dx_f)
    );
    cbc_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go), .i_num(r_ny),
        .i_den(r_dep), .o_done(dy_done), .o_quot(o_py), .o_fault(dy_f)
    );

    assign o_status = {(r_xd | dx_done) & (r_yd | dy_done), r_vis};
    assign o_fault = dx_f | dy_f;
endmodule

// File: rtl/cbc_ctrl.sv
// Controller: walks faces for culling, then visible faces and corners for output.
module cbc_ctrl #(
    parameter int FACE_COUNT = cbc_pkg::FACE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_cfg_ready,
    output cbc_pkg::t_cmd         o_cmd,
    input  cbc_pkg::t_status      i_status,
    input  logic signed [31:0]    i_px,
    input  logic signed [31:0]    i_py,
    input  logic                  i_fault,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cbc_pkg::t_out_item    o_out
);
    import cbc_pkg::*;

    localparam int WALK = (FACE_COUNT > 6) ? 6 : FACE_COUNT;
    localparam logic [2:0] LAST_FACE = 3'(WALK - 1);

    t_op        r_op, n_op;
    logic [2:0] r_face, n_face;
    logic [2:0] r_slot, n_slot;
    logic       r_wait, n_wait;
    logic       r_ov, n_ov;
    t_out_item  r_out, n_out;
    logic [2:0] cnt;
    logic       more;
    logic [2:0] nxt;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < 6; i++) begin
            cnt = cnt + 3'(i_status.vis[i]);
        end
        more = 1'b0;
        nxt = r_face;
        for (int i = 5; i >= 0; i--) begin
            if (3'(i) > r_face && i_status.vis[i]) begin
                more = 1'b1;
                nxt = 3'(i);
            end
        end
    end

    always_comb begin
        n_op = r_op;
        n_face = r_face;
        n_slot = r_slot;
        n_wait = r_wait;
        n_ov = r_ov;
        n_out = r_out;
        o_cmd = '0;
        o_cmd.face = r_face;
        o_cmd.slot = r_slot;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        case (r_op)
            OP_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_face = '0;
                    n_op = OP_CULL;
                end
            end
            OP_CULL: begin
                o_cmd.cull = 1'b1;
                if (r_face == LAST_FACE) begin
                    n_op = OP_LOAD;
                end else begin
                    n_face = r_face + 3'd1;
                end
            end
            OP_LOAD: begin
                if (cnt == '0) begin
                    if (!n_ov) begin
                        n_ov = 1'b1;
                        n_out = '0;
                        n_out.last = 1'b1;
                        n_op = OP_IDLE;
                    end
                end else begin
                    n_face = i_status.vis[0] ? 3'd0 : nxt;
                    if (!i_status.vis[0]) begin
                        n_face = '0;
                        for (int i = 5; i >= 1; i--) begin
                            if (i_status.vis[i]) n_face = 3'(i);
                        end
                    end
                    n_slot = '0;
                    n_wait = 1'b0;
                    n_op = OP_PROJ;
                end
            end
            OP_PROJ: begin
                if (!r_wait) begin
                    o_cmd.proj_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_status.div_done && !n_ov) begin
                    n_ov = 1'b1;
                    n_out.proj_x = i_px;
                    n_out.proj_y = i_py;
                    n_out.face_number = r_face;
                    n_out.corner_slot = r_slot;
                    n_out.vertex_valid = 1'b1;
                    n_out.divide_fault = i_fault;
                    n_out.visible_faces = cnt;
                    n_out.last = (r_slot == 3'(CORNERS - 1)) && !more;
                    n_wait = 1'b0;
                    if (r_slot == 3'(CORNERS - 1)) begin
                        n_slot = '0;
                        if (more) begin
                            n_face = nxt;
                        end else begin
                            n_op = OP_IDLE;
                        end
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                end
            end
            default: n_op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_IDLE;
            r_ov <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            r_op <= n_op;
            r_ov <= n_ov;
            r_wait <= n_wait;
        end
        r_face <= n_face;
        r_slot <= n_slot;
        r_out <= n_out;
    end

    assign o_in_stall = (r_op != OP_IDLE);
    assign o_cfg_ready = (r_op == OP_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule

// File: rtl/cube_backface_cull_project_unit.sv
// Top level of the cube back-face cull and perspective projection unit.
//
//  channel   direction  handshake             payload
//  in        input      i_in_valid/o_in_stall t_in_item
//  out       output     o_out_valid/i_out_stall t_out_item
//  cfg       input      i_cfg_valid/o_cfg_ready screen distance
//
// A transaction on the input culls each face, then projects each corner of
// every visible face with the two 66-step serial dividers; the input stalls
// until the controller is idle again. Reset is synchronous and active low.
// A stalled output holds its result while the next divide runs, then waits.
`include "assert_macros.svh"
module cube_backface_cull_project_unit #(
    parameter int FACE_COUNT = cbc_pkg::FACE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cbc_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cbc_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [30:0]           i_cfg_data
);
    import cbc_pkg::*;

    logic [30:0]        r_sdist;
    t_cmd               cmd;
    t_status            status;
    logic signed [31:0] px, py;
    logic               fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdist <= SDIST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sdist <= i_cfg_data;
        end
    end

    cbc_ctrl #(.FACE_COUNT(FACE_COUNT)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_cfg_ready(o_cfg_ready), .o_cmd(cmd),
        .i_status(status), .i_px(px), .i_py(py), .i_fault(fault),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out_data)
    );

    cbc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(i_in_data),
        .i_sdist(r_sdist), .o_status(status), .o_px(px), .o_py(py), .o_fault(fault)
    );

    `CBC_ASSERT_IMP(a_valid_vis, i_clk, i_rst_n, o_out_valid && !o_out_data.vertex_valid,
        o_out_data.last && o_out_data.visible_faces == 3'd0)
    `CBC_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, o_in_stall == 1'b0)
    `CBC_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule

// File: bench/cube_backface_cull_project_unit_tb.sv
// Self-checking testbench for the cube back-face cull and projection unit.
module cube_backface_cull_project_unit_tb;
    import cbc_pkg::*;

    localparam int  LIMIT_CYCLES = 5000000;
    localparam int  HALF = 32768;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data = '0;

    t_out_item   vertex_q[$];
    logic [30:0] screen_dist;
    bit          calm;
    int          errors;
    int          cycles;

    int corner_tab[8][3] = '{'{-1, -1, 5}, '{-1, 1, 5}, '{1, 1, 5}, '{1, -1, 5},
                             '{-1, -1, 7}, '{-1, 1, 7}, '{1, 1, 7}, '{1, -1, 7}};
    int face_tab[6][6] = '{'{0, 1, 2, 2, 3, 0}, '{7, 6, 5, 5, 4, 7},
                           '{4, 5, 1, 1, 0, 4}, '{3, 2, 6, 6, 7, 3},
                           '{1, 5, 6, 6, 2, 1}, '{3, 7, 4, 4, 0, 3}};

    cube_backface_cull_project_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    function automatic longint project_axis(longint diff, longint depth, inout bit fault);
        longint num;
        longint q;
        num = diff * longint'(screen_dist);
        if (depth == 0) begin
            fault = 1'b1;
            return (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 64'sd0);
        end
        q = num / depth;
        if (q > 64'sd2147483647) begin
            fault = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            fault = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic void predict_vertices(t_in_item it);
        longint    eye[3];
        bit        vis[6];
        int        count;
        int        a[3];
        int        b[3];
        longint    nrm[3];
        longint    dot;
        longint    depth;
        bit        fault;
        int        c;
        t_out_item v;
        eye[0] = it.eye_x;
        eye[1] = it.eye_y;
        eye[2] = it.eye_z;
        count = 0;
        for (int f = 0; f < 6; f++) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = corner_tab[face_tab[f][1]][i] - corner_tab[face_tab[f][0]][i];
                b[i] = corner_tab[face_tab[f][2]][i] - corner_tab[face_tab[f][1]][i];
            end
            nrm[0] = a[1] * b[2] - a[2] * b[1];
            nrm[1] = a[2] * b[0] - a[0] * b[2];
            nrm[2] = a[0] * b[1] - a[1] * b[0];
            dot = 0;
            for (int i = 0; i < 3; i++) begin
                dot += nrm[i] * (longint'(corner_tab[face_tab[f][0]][i]) * HALF - eye[i]);
            end
            vis[f] = dot < 0;
            if (vis[f]) begin
                count++;
            end
        end
        if (count == 0) begin
            v = '0;
            v.last = 1'b1;
            vertex_q.insert(vertex_q.size(), v);
            return;
        end
        for (int f = 0; f < 6; f++) begin
            if (vis[f]) begin
                for (int s = 0; s < 6; s++) begin
                    c = face_tab[f][s];
                    fault = 1'b0;
                    depth = longint'(corner_tab[c][2]) * HALF - eye[2];
                    v.proj_x = 32'(project_axis(longint'(corner_tab[c][0]) * HALF - eye[0],
                                                depth, fault));
                    v.proj_y = 32'(project_axis(longint'(corner_tab[c][1]) * HALF - eye[1],
                                                depth, fault));
                    v.face_number = 3'(f);
                    v.corner_slot = 3'(s);
                    v.vertex_valid = 1'b1;
                    v.divide_fault = fault;
                    v.visible_faces = 3'(count);
                    v.last = 1'b0;
                    vertex_q.insert(vertex_q.size(), v);
                end
            end
        end
        vertex_q[vertex_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (vertex_q.size() == 0) begin
                $display("%0t unexpected transaction: expected none actual %p",
                         $time, o_out_data);
                errors++;
            end else begin
                want = vertex_q.pop_front();
                if (o_out_data.proj_x !== want.proj_x || o_out_data.proj_y !== want.proj_y ||
                    o_out_data.face_number !== want.face_number ||
                    o_out_data.corner_slot !== want.corner_slot ||
                    o_out_data.vertex_valid !== want.vertex_valid ||
                    o_out_data.divide_fault !== want.divide_fault ||
                    o_out_data.visible_faces !== want.visible_faces ||
                    o_out_data.last !== want.last) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, o_out_data);
                    errors++;
                end
            end
        end
    end

    task automatic send_eye(input logic [31:0] ex, input logic [31:0] ey,
                            input logic [31:0] ez);
        t_in_item it;
        it.eye_x = ex;
        it.eye_y = ey;
        it.eye_z = ez;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_vertices(it);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_distance(input logic [30:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        screen_dist = d;
    endtask

    function automatic logic [31:0] near_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'(5 * HALF);
        if (r == 1) return 32'(7 * HALF);
        if (r == 2) return $urandom;
        return 32'($signed($urandom_range(0, 1048576)) - 524288);
    endfunction

    task automatic test_directed();
        send_eye(32'd0, 32'd0, 32'sh0000_0000);
        send_eye(32'd0, 32'd0, 32'(6 * 65536));
        send_eye(32'd0, 32'd0, 32'(5 * HALF));
        send_eye(32'd0, 32'd0, 32'(7 * HALF));
        send_eye(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eye(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eye(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_eye(32'h7FFF_FFFF, 32'h8000_0000, 32'(20 * 65536));
        send_eye(32'(3 * 65536), 32'(3 * 65536), 32'd0);
        send_eye(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_eye(32'd0, 32'(HALF), 32'(3 * 65536));
        send_eye(32'(2 * 65536), 32'd0, 32'(6 * 65536));
        send_eye(32'd0, 32'd0, 32'(6 * 65536 - 1));
        drain();
    endtask

    task automatic test_distance_extremes();
        write_distance(31'd0);
        send_eye(32'd0, 32'd0, 32'd0);
        send_eye(32'(HALF), 32'd0, 32'(5 * HALF));
        drain();
        write_distance(31'h7FFF_FFFF);
        send_eye(32'd0, 32'd0, 32'd0);
        send_eye(32'd0, 32'd0, 32'(5 * HALF - 1));
        send_eye(32'h8000_0000, 32'h7FFF_FFFF, 32'(5 * HALF - 2));
        send_eye(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        drain();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3) && (k < n / 2);
            send_eye(near_coord(), near_coord(), near_coord());
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        screen_dist = SDIST_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_distance_extremes();
        write_distance(SDIST_RESET);
        test_random(80);
        write_distance(31'($urandom));
        test_random(60);
        write_distance(31'($urandom_range(1, 1 << 20)));
        test_random(60);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
